FILE: rtl/ditf_pkg.sv
// ----------------------------------------------------------------------------
// ditf_pkg
// Shared types, constants and helpers for the integer to decimal text block.
// ----------------------------------------------------------------------------
package ditf_pkg;

  localparam int unsigned MagWidth  = 32;
  localparam int unsigned NumDigits = 10;
  localparam int unsigned StepBits  = 2;
  localparam int unsigned NumSteps  = MagWidth / StepBits;
  localparam int unsigned IdxWidth  = $clog2(NumDigits);
  localparam int unsigned StepWidth = $clog2(NumSteps);

  localparam logic [7:0] AsciiZero  = 8'd48;
  localparam logic [7:0] AsciiMinus = 8'd45;
  localparam logic [7:0] AsciiComma = 8'd44;

  typedef logic [3:0] bcd_t;

  // Control that every cell of the chain sees in the same cycle.
  typedef struct packed {
    logic clear;
    logic shift;
  } cell_ctrl_t;

  // Double dabble correction: a digit of five or more gets three added
  // before it is doubled.
  function automatic bcd_t bcd_adjust(input bcd_t d);
    bcd_t r;
    r = (d >= 4'd5) ? bcd_t'(d + 4'd3) : d;
    return r;
  endfunction

endpackage

FILE: rtl/ditf_cell.sv
// ----------------------------------------------------------------------------
// ditf_cell
// One decimal digit of the shift-and-add-3 chain, two bits per cycle while shift is set.
// ----------------------------------------------------------------------------
module ditf_cell import ditf_pkg::*; (
  input  logic       clk_i,
  input  cell_ctrl_t ctrl_i,
  input  logic [1:0] bits_i,
  output logic [1:0] carry_o,
  output bcd_t       digit_o
);

  bcd_t digit_q, digit_d;
  bcd_t s1, t1, s2, t2;

  // The first carry depends only on this cell's own digit, so the second
  // bit never ripples further than one neighbor.
  always_comb begin
    s1 = bcd_adjust(digit_q);
    t1 = {s1[2:0], bits_i[1]};
    s2 = bcd_adjust(t1);
    t2 = {s2[2:0], bits_i[0]};
    carry_o = {s1[3], s2[3]};
    if (ctrl_i.clear) begin
      digit_d = '0;
    end else if (ctrl_i.shift) begin
      digit_d = t2;
    end else begin
      digit_d = digit_q;
    end
  end

  always_ff @(posedge clk_i) begin
    digit_q <= digit_d;
  end

  assign digit_o = digit_q;

endmodule

FILE: rtl/ditf_chain.sv
// ----------------------------------------------------------------------------
// ditf_chain
// Row of digit cells with the magnitude bits entering at the low end, and
// the position of the most significant nonzero digit.
// ----------------------------------------------------------------------------
module ditf_chain import ditf_pkg::*; (
  input  logic                          clk_i,
  input  cell_ctrl_t                    ctrl_i,
  input  logic [StepBits-1:0]           bits_i,
  output logic [NumDigits-1:0][3:0]     digits_o,
  output logic [IdxWidth-1:0]           msd_o
);

  logic [NumDigits:0][1:0] link;

  assign link[0] = bits_i;

  for (genvar g = 0; g < NumDigits; g++) begin : g_cell
    ditf_cell u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl_i),
      .bits_i  (link[g]),
      .carry_o (link[g+1]),
      .digit_o (digits_o[g])
    );
  end

  // Highest nonzero digit; an all-zero row still shows one digit.
  always_comb begin
    msd_o = '0;
    for (int k = 0; k < NumDigits; k++) begin
      if (digits_o[k] != 4'd0) begin
        msd_o = IdxWidth'(k);
      end
    end
  end

endmodule

FILE: rtl/int_to_decimal_fraction_text.sv
// ----------------------------------------------------------------------------
// int_to_decimal_fraction_text
// Converts a signed 32-bit value to ASCII text: "0," before a negative
// value, "-0," before a non-negative one, then the decimal magnitude.
// ----------------------------------------------------------------------------
// Conversion: the digit chain takes the magnitude two bits per cycle, then the
// characters go out one per cycle into the output register while the output
// does not stall. A value gives 3 to 13 characters; no new beat is accepted
// until the last character of the previous one has been registered.
// Reset: asynchronous, active low; returns to idle with no beat pending.
module int_to_decimal_fraction_text import ditf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] value_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  char_code_o,
  output logic        is_last_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CONV,
    S_MINUS,
    S_ZERO,
    S_COMMA,
    S_DIGIT
  } state_e;

  state_e                  state_q;
  logic [MagWidth-1:0]     mag_q;
  logic                    neg_q;
  logic [StepWidth-1:0]    step_q;
  logic [IdxWidth-1:0]     idx_q;
  logic                    out_valid_q;
  logic [7:0]              char_q;
  logic                    last_q;

  cell_ctrl_t              chain_ctrl;
  logic [NumDigits-1:0][3:0] digits;
  logic [IdxWidth-1:0]     msd;
  logic                    accept;
  logic                    emit;
  logic                    emitting;
  logic [MagWidth-1:0]     magnitude;

  assign accept    = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE);
  assign emitting  = (state_q == S_MINUS) || (state_q == S_ZERO) ||
                     (state_q == S_COMMA) || (state_q == S_DIGIT);
  assign emit      = emitting && (!out_valid_q || !out_stall_i);
  assign magnitude = value_i[31] ? (MagWidth'(0) - value_i) : value_i;

  assign chain_ctrl.clear = accept;
  assign chain_ctrl.shift = (state_q == S_CONV);

  ditf_chain u_chain (
    .clk_i    (clk_i),
    .ctrl_i   (chain_ctrl),
    .bits_i   (mag_q[MagWidth-1 -: StepBits]),
    .digits_o (digits),
    .msd_o    (msd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= '0;
      idx_q       <= '0;
      neg_q       <= 1'b0;
      out_valid_q <= 1'b0;
      mag_q       <= '0;
      char_q      <= '0;
      last_q      <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i && !emit) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            mag_q   <= magnitude;
            neg_q   <= value_i[31];
            step_q  <= '0;
            state_q <= S_CONV;
          end
        end
        S_CONV: begin
          mag_q  <= mag_q << StepBits;
          step_q <= step_q + 1'b1;
          if (step_q == StepWidth'(NumSteps - 1)) begin
            state_q <= neg_q ? S_ZERO : S_MINUS;
          end
        end
        S_MINUS: begin
          if (emit) begin
            out_valid_q <= 1'b1;
            char_q      <= AsciiMinus;
            last_q      <= 1'b0;
            state_q     <= S_ZERO;
          end
        end
        S_ZERO: begin
          if (emit) begin
            out_valid_q <= 1'b1;
            char_q      <= AsciiZero;
            last_q      <= 1'b0;
            state_q     <= S_COMMA;
          end
        end
        S_COMMA: begin
          if (emit) begin
            out_valid_q <= 1'b1;
            char_q      <= AsciiComma;
            last_q      <= 1'b0;
            idx_q       <= msd;
            state_q     <= S_DIGIT;
          end
        end
        S_DIGIT: begin
          if (emit) begin
            out_valid_q <= 1'b1;
            char_q      <= AsciiZero + {4'd0, digits[idx_q]};
            last_q      <= (idx_q == '0);
            if (idx_q == '0) begin
              state_q <= S_IDLE;
            end else begin
              idx_q <= idx_q - 1'b1;
            end
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign char_code_o = char_q;
  assign is_last_o   = last_q;

  // The step counter wraps to zero exactly as conversion ends.
  a_step_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_CONV) |-> (step_q == '0))
    else $error("step counter nonzero outside conversion");

  a_accept_conv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == S_CONV))
    else $error("accepted beat did not start conversion");

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIGIT) |-> (idx_q <= IdxWidth'(NumDigits - 1)))
    else $error("digit index out of range");

  a_digit_bcd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIGIT) |-> (digits[idx_q] <= 4'd9))
    else $error("digit chain holds a non-decimal digit");

  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && (state_q == S_DIGIT) && (idx_q == '0)) |=> (state_q == S_IDLE))
    else $error("final character did not return to idle");

endmodule

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for int_to_decimal_fraction_text. Each signed value that
// is sent is turned into its expected character beats by a predictor in this
// file. Every output beat is checked against the oldest expected beat, and
// both sides of the handshake stall at random.
// ----------------------------------------------------------------------------
module testbench;
  import ditf_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WatchdogLimit = 4000;
  localparam int unsigned HoldCycles    = 400;
  localparam int unsigned DrainCycles   = 40;
  localparam int unsigned ReportCap     = 100;

  typedef struct packed {
    logic [7:0] code;
    logic       last;
  } char_beat_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [31:0] value_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [7:0]  char_code_o;
  logic        is_last_o;

  char_beat_t  expected_chars[$];
  int unsigned error_count = 0;
  int unsigned idle_cycles = 0;
  bit          idle_en = 1'b1;
  bit          hold_req = 1'b0;

  int_to_decimal_fraction_text dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .value_i    (value_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .char_code_o(char_code_o),
    .is_last_o  (is_last_o)
  );

  always #1 clk_i = ~clk_i;

  task automatic report(input string msg);
    if (error_count < ReportCap) begin
      $display("ERROR @%0t: %s", $realtime, msg);
    end
    error_count++;
  endtask

  // Builds the character beats for one value: the inverted sign prefix, then
  // the magnitude digits, most significant first.
  function automatic void predict_text(input logic [31:0] v);
    logic [31:0] mag;
    logic [3:0]  digits[NumDigits];
    int          nd;
    char_beat_t  b;
    mag = v[31] ? -v : v;
    nd = 0;
    do begin
      digits[nd] = 4'(mag % 10);
      mag = mag / 10;
      nd++;
    end while (mag != 0 && nd < NumDigits);
    if (!v[31]) begin
      b.code = AsciiMinus;
      b.last = 1'b0;
      expected_chars.push_back(b);
    end
    b.code = AsciiZero;
    b.last = 1'b0;
    expected_chars.push_back(b);
    b.code = AsciiComma;
    expected_chars.push_back(b);
    for (int i = nd - 1; i >= 0; i--) begin
      b.code = AsciiZero + 8'(digits[i]);
      b.last = (i == 0);
      expected_chars.push_back(b);
    end
  endfunction

  // Either any 32-bit pattern, or a value with a chosen number of digits.
  function automatic logic [31:0] random_value();
    longint lo;
    longint hi;
    longint mag;
    int     len;
    bit     neg;
    if ($urandom_range(0, 3) == 0) begin
      return $urandom;
    end
    len = $urandom_range(1, 10);
    neg = $urandom_range(0, 1);
    lo = (len == 1) ? 0 : 1;
    for (int i = 1; i < len; i++) begin
      lo = lo * 10;
    end
    hi = lo * 10 - 1;
    if (len == 1) hi = 9;
    if (neg && hi > 64'sd2147483648) hi = 64'sd2147483648;
    if (!neg && hi > 64'sd2147483647) hi = 64'sd2147483647;
    mag = lo + (longint'($urandom) % (hi - lo + 1));
    return neg ? 32'(-mag) : 32'(mag);
  endfunction

  // Offers one value and returns once it has been taken. A gap, when there is
  // one, starts in the step of the previous acceptance.
  task automatic send_value(input logic [31:0] v);
    int unsigned gap;
    gap = 0;
    if (idle_en && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 17);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      value_i    <= $urandom;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    value_i    <= v;
    do @(posedge clk_i); while (in_stall_o);
    predict_text(v);
  endtask

  task automatic test_directed();
    logic [31:0] vals[$];
    vals = '{32'd0, 32'd1, -32'sd1, 32'd9, 32'd10, -32'sd10, 32'd100, -32'sd100,
             32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001, 32'd1000000000,
             32'd999999999, -32'sd999999999, 32'd123456789, -32'sd123456789,
             32'd1999999999, -32'sd2000000000, 32'h5555_5555, 32'hAAAA_AAAA};
    foreach (vals[i]) send_value(vals[i]);
  endtask

  // The receiver holds off for a long stretch while values keep coming, so
  // the block fills up and stalls its input.
  task automatic test_backpressure();
    hold_req = 1'b1;
    for (int i = 0; i < 30; i++) send_value(random_value());
  endtask

  task automatic test_random(input int n);
    for (int i = 0; i < n; i++) send_value(random_value());
  endtask

  task automatic test_steady(input int n);
    idle_en = 1'b0;
    for (int i = 0; i < n; i++) send_value(random_value());
  endtask

  // Receiver side: random stall bursts, quiet stretches, and the long hold.
  initial begin
    int unsigned held;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_stall_i <= 1'b1;
        held = 0;
        while (held < HoldCycles) begin
          @(posedge clk_i);
          held++;
        end
        hold_req = 1'b0;
        out_stall_i <= 1'b0;
      end else if (idle_en && $urandom_range(0, 4) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 17)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end else begin
        out_stall_i <= 1'b0;
        repeat ($urandom_range(1, 20)) @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    char_beat_t exp_beat;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_chars.size() == 0) begin
        report($sformatf("unexpected beat: code %0d last %0b", char_code_o, is_last_o));
      end else begin
        exp_beat = expected_chars.pop_front();
        if (char_code_o !== exp_beat.code) begin
          report($sformatf("char_code: got %0d, want %0d", char_code_o, exp_beat.code));
        end
        if (is_last_o !== exp_beat.last) begin
          report($sformatf("is_last: got %0b, want %0b", is_last_o, exp_beat.last));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles + 1 >= WatchdogLimit) begin
        $display("FAIL int_to_decimal_fraction_text");
        $finish;
      end
    end
  end

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (3) @(posedge clk_i);
    test_directed();
    test_backpressure();
    test_random(300);
    test_steady(70);
    in_valid_i <= 1'b0;
    while (expected_chars.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (error_count == 0) begin
      $display("PASS int_to_decimal_fraction_text");
    end else begin
      $display("FAIL int_to_decimal_fraction_text");
    end
    $finish;
  end

endmodule

FILE: int_to_decimal_fraction_text.f
rtl/ditf_pkg.sv
rtl/ditf_cell.sv
rtl/ditf_chain.sv
rtl/int_to_decimal_fraction_text.sv
tb/testbench.sv
